@@ design/spherical_monomial_basis_unit_assert.svh @@
// Assertion macros used by the checker file smb_checker.sv
`ifndef SPHERICAL_MONOMIAL_BASIS_UNIT_ASSERT_SVH
`define SPHERICAL_MONOMIAL_BASIS_UNIT_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define SMB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define SMB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/smb_pkg.sv @@
`default_nettype none
package smb_pkg;

    // input transaction
    typedef struct packed {
        logic signed [15:0] mu;
        logic        [15:0] phi;
        logic        [15:0] radius;
    } in_item_t;

    // result transaction
    typedef struct packed {
        logic signed [15:0] value;
        logic        [5:0]  position;
        logic               last;
    } out_item_t;

    // direction components, Q1.15
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } comp_t;

    // configuration seen by the back end
    typedef struct packed {
        logic [2:0] max_degree;
        logic [1:0] spatial_dim;
    } cfg_t;

    // register indexes (paddr[2])
    localparam logic REG_MAX_DEGREE  = 1'b0;
    localparam logic REG_SPATIAL_DIM = 1'b1;

    localparam logic [2:0] MAX_DEGREE_RESET  = 3'd0;
    localparam logic [1:0] SPATIAL_DIM_RESET = 2'd3;

    // dimension codes; anything else is 3D
    localparam logic [1:0] DIM_Z_ONLY = 2'd1;
    localparam logic [1:0] DIM_XY     = 2'd2;

    // CORDIC gain 0.607252935 as Q0.32
    localparam logic [31:0] GAIN_Q32 = 32'd2608131496;

    localparam logic signed [16:0] Q15_ONE   = 17'sd32768;
    localparam logic signed [33:0] Q15_ROUND = 34'sd16384;

    // clamp to the Q1.15 range
    function automatic logic signed [15:0] sat_q15(input logic signed [63:0] v);
        logic signed [15:0] r;
        if (v > 64'sd32767)
            r = 16'sh7fff;
        else if (v < -64'sd32768)
            r = 16'sh8000;
        else
            r = v[15:0];
        return r;
    endfunction

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:  r = 30'd536870912;
            5'd1:  r = 30'd316933406;
            5'd2:  r = 30'd167458907;
            5'd3:  r = 30'd85004756;
            5'd4:  r = 30'd42667331;
            5'd5:  r = 30'd21354465;
            5'd6:  r = 30'd10679838;
            5'd7:  r = 30'd5340245;
            5'd8:  r = 30'd2670163;
            5'd9:  r = 30'd1335087;
            5'd10: r = 30'd667544;
            5'd11: r = 30'd333772;
            5'd12: r = 30'd166886;
            5'd13: r = 30'd83443;
            5'd14: r = 30'd41722;
            5'd15: r = 30'd20861;
            5'd16: r = 30'd10430;
            5'd17: r = 30'd5215;
            5'd18: r = 30'd2608;
            5'd19: r = 30'd1304;
            5'd20: r = 30'd652;
            5'd21: r = 30'd326;
            5'd22: r = 30'd163;
            5'd23: r = 30'd81;
            5'd24: r = 30'd41;
            5'd25: r = 30'd20;
            5'd26: r = 30'd10;
            5'd27: r = 30'd5;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            5'd30: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/smb_fifo.sv @@
`default_nettype none
module smb_fifo #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] rdata
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == NW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end
endmodule
`default_nettype wire

@@ design/smb_front.sv @@
`default_nettype none
module smb_front #(
    parameter int FRAC_BITS    = 15,
    parameter int CORDIC_STEPS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             busy,
    input  smb_pkg::in_item_t item,
    output logic             comp_push,
    input  logic             comp_full,
    output smb_pkg::comp_t   comp
);
    localparam int F     = FRAC_BITS;
    localparam int OMW   = 2 * F + 1;
    localparam int OM_UP = (2 * F >= 30) ? 2 * F - 30 : 0;
    localparam int OM_DN = (2 * F < 30) ? 30 - 2 * F : 0;
    localparam int OMT   = 31 + OM_UP;
    localparam int RW    = F + 1;
    localparam int R_UP  = (F >= 15) ? F - 15 : 0;
    localparam int R_DN  = (F < 15) ? 15 - F : 0;
    localparam int RT    = 16 + R_UP;
    localparam int P1W   = 2 * F + 2;
    localparam int P2W   = F + 33;
    localparam int XW    = F + 4;
    localparam int SH_DN = (F > 15) ? F - 15 : 0;
    localparam int SH_UP = (F < 15) ? 15 - F : 0;
    localparam int QT    = XW + SH_UP + 1;
    localparam int RND_Q = (F > 15) ? (1 << ((F > 15) ? F - 16 : 0)) : 0;
    localparam int MAXIT = (F + 1 > CORDIC_STEPS) ? F + 1 : CORDIC_STEPS;
    localparam int CNTW  = $clog2(MAXIT + 1);

    typedef enum logic [2:0] {
        F_IDLE, F_SQRT, F_MUL1, F_MUL2, F_INIT, F_ITER, F_OUT
    } fstate_t;

    fstate_t                 state_reg;
    logic signed [15:0]      mu_reg;
    logic        [15:0]      phi_reg;
    logic        [15:0]      rad_reg;
    logic        [OMW-1:0]   sq_v_reg;
    logic        [OMW-1:0]   sq_res_reg;
    logic        [OMW-1:0]   sq_bit_reg;
    logic        [CNTW-1:0]  cnt_reg;
    logic        [P1W-1:0]   prod1_reg;
    logic        [P2W-1:0]   prod2_reg;
    logic signed [XW-1:0]    x_reg;
    logic signed [XW-1:0]    y_reg;
    logic signed [32:0]      ang_reg;
    logic signed [15:0]      comp_z_reg;

    logic signed [31:0]      mu_sq;
    logic        [30:0]      om30;
    logic        [OMT-1:0]   om_t;
    logic        [OMW:0]     sq_trial;
    logic                    sq_ge;
    logic        [RT-1:0]    r_t;
    logic        [RW-1:0]    r_val;
    logic        [P1W:0]     rho_t;
    logic        [F:0]       rho;
    logic        [P2W:0]     x0_t;
    logic        [F:0]       x0;
    logic signed [XW-1:0]    x0s;
    logic        [15:0]      phi_sum;
    logic        [1:0]       quad;
    logic        [15:0]      resid;
    logic signed [33:0]      zp;
    logic        [4:0]       idx;
    logic signed [XW-1:0]    dx;
    logic signed [XW-1:0]    dy;
    logic signed [32:0]      atan_v;
    logic signed [QT-1:0]    tx;
    logic signed [QT-1:0]    ty;

    assign busy      = (state_reg != F_IDLE);
    assign comp_push = (state_reg == F_OUT);

    // 1 - mu^2 rescaled to 2*F fraction bits
    always_comb
    begin
        mu_sq = item.mu * item.mu;
        om30  = 31'(32'd1073741824 - $unsigned(mu_sq));
        om_t  = (OMT'(om30) << OM_UP) >> OM_DN;
    end

    // one square-root step
    always_comb
    begin
        sq_trial = {1'b0, sq_res_reg} + {1'b0, sq_bit_reg};
        sq_ge    = ({1'b0, sq_v_reg} >= sq_trial);
    end

    // radius, rho and gain scaling
    always_comb
    begin
        r_t   = (RT'(rad_reg) << R_UP) >> R_DN;
        r_val = RW'(r_t);
        rho_t = (P1W + 1)'(prod1_reg) + (P1W + 1)'(1 << (F - 1));
        rho   = (F + 1)'(rho_t >> F);
        x0_t  = (P2W + 1)'(prod2_reg) + (P2W + 1)'(33'h0_8000_0000);
        x0    = (F + 1)'(x0_t >> 32);
        x0s   = XW'($signed({1'b0, x0}));
    end

    // quadrant, residual angle and z product
    always_comb
    begin
        phi_sum = phi_reg + 16'h2000;
        quad    = phi_sum[15:14];
        resid   = phi_reg - {quad, 14'b0};
        zp      = $signed({{18{mu_reg[15]}}, mu_reg}) * $signed({18'b0, rad_reg});
    end

    // CORDIC step operands
    always_comb
    begin
        idx    = 5'(cnt_reg);
        dx     = y_reg >>> idx;
        dy     = x_reg >>> idx;
        atan_v = $signed({3'b0, smb_pkg::atan_turn(idx)});
    end

    // round to Q1.15 and saturate
    always_comb
    begin
        tx = (QT'(x_reg) + QT'(RND_Q)) >>> SH_DN;
        tx = tx <<< SH_UP;
        ty = (QT'(y_reg) + QT'(RND_Q)) >>> SH_DN;
        ty = ty <<< SH_UP;
        comp.x = smb_pkg::sat_q15(64'(tx));
        comp.y = smb_pkg::sat_q15(64'(ty));
        comp.z = comp_z_reg;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= F_IDLE;
            mu_reg     <= '0;
            phi_reg    <= '0;
            rad_reg    <= '0;
            sq_v_reg   <= '0;
            sq_res_reg <= '0;
            sq_bit_reg <= '0;
            cnt_reg    <= '0;
            prod1_reg  <= '0;
            prod2_reg  <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            ang_reg    <= '0;
            comp_z_reg <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (push)
                    begin
                        mu_reg     <= item.mu;
                        phi_reg    <= item.phi;
                        rad_reg    <= item.radius;
                        sq_v_reg   <= OMW'(om_t);
                        sq_res_reg <= '0;
                        sq_bit_reg <= OMW'(1) << (2 * F);
                        cnt_reg    <= '0;
                        state_reg  <= F_SQRT;
                    end
                end
                F_SQRT:
                begin
                    if (sq_ge)
                    begin
                        sq_v_reg   <= OMW'({1'b0, sq_v_reg} - sq_trial);
                        sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    end
                    else
                    begin
                        sq_res_reg <= sq_res_reg >> 1;
                    end
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (cnt_reg == CNTW'(F))
                        state_reg <= F_MUL1;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                F_MUL1:
                begin
                    prod1_reg <= P1W'(r_val) * P1W'(sq_res_reg[F:0]);
                    state_reg <= F_MUL2;
                end
                F_MUL2:
                begin
                    prod2_reg <= P2W'(rho) * P2W'(smb_pkg::GAIN_Q32);
                    state_reg <= F_INIT;
                end
                F_INIT:
                begin
                    case (quad)
                        2'd0:
                        begin
                            x_reg <= x0s;
                            y_reg <= '0;
                        end
                        2'd1:
                        begin
                            x_reg <= '0;
                            y_reg <= x0s;
                        end
                        2'd2:
                        begin
                            x_reg <= -x0s;
                            y_reg <= '0;
                        end
                        default:
                        begin
                            x_reg <= '0;
                            y_reg <= -x0s;
                        end
                    endcase
                    ang_reg    <= $signed({resid[15], resid, 16'h0000});
                    comp_z_reg <= smb_pkg::sat_q15(64'((zp + smb_pkg::Q15_ROUND) >>> 15));
                    cnt_reg    <= '0;
                    state_reg  <= F_ITER;
                end
                F_ITER:
                begin
                    if (ang_reg >= 0)
                    begin
                        x_reg   <= x_reg - dx;
                        y_reg   <= y_reg + dy;
                        ang_reg <= ang_reg - atan_v;
                    end
                    else
                    begin
                        x_reg   <= x_reg + dx;
                        y_reg   <= y_reg - dy;
                        ang_reg <= ang_reg + atan_v;
                    end
                    if (cnt_reg == CNTW'(CORDIC_STEPS - 1))
                        state_reg <= F_OUT;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                F_OUT:
                begin
                    if (!comp_full)
                        state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/smb_back.sv @@
`default_nettype none
module smb_back #(
    parameter int MAX_DEGREE_LIMIT = 5
) (
    input  logic               clk,
    input  logic               rst_n,
    input  smb_pkg::cfg_t      cfg,
    input  logic               comp_empty,
    output logic               comp_pop,
    input  smb_pkg::comp_t     comp,
    output logic               res_push,
    input  logic               res_full,
    output smb_pkg::out_item_t result
);
    typedef enum logic {
        B_IDLE, B_CALC
    } bstate_t;

    bstate_t            state_reg;
    logic signed [15:0] x_reg;
    logic signed [15:0] y_reg;
    logic signed [15:0] z_reg;
    logic        [2:0]  deg_reg;
    logic        [2:0]  exp_a_reg;
    logic        [2:0]  exp_b_reg;
    logic        [2:0]  ra_reg;
    logic        [2:0]  rb_reg;
    logic        [2:0]  rc_reg;
    logic signed [16:0] acc_reg;
    logic        [5:0]  pos_reg;

    logic        [2:0]  dmax;
    logic               is_z_only;
    logic               is_xy;
    logic               is_last;
    logic               mul_busy;
    logic signed [15:0] operand;
    logic signed [32:0] prod;
    logic signed [33:0] prod_rnd;
    logic        [2:0]  nd;
    logic        [2:0]  na;
    logic        [2:0]  nb;

    assign dmax      = (cfg.max_degree > 3'(MAX_DEGREE_LIMIT)) ?
                       3'(MAX_DEGREE_LIMIT) : cfg.max_degree;
    assign is_z_only = (cfg.spatial_dim == smb_pkg::DIM_Z_ONLY);
    assign is_xy     = (cfg.spatial_dim == smb_pkg::DIM_XY);
    assign is_last   = (deg_reg == dmax) && (is_z_only || (exp_a_reg == deg_reg));
    assign mul_busy  = (ra_reg != '0) || (rb_reg != '0) || (rc_reg != '0);
    assign comp_pop  = (state_reg == B_IDLE) && !comp_empty;
    assign res_push  = (state_reg == B_CALC) && !mul_busy && !res_full;

    assign result.value    = smb_pkg::sat_q15(64'(acc_reg));
    assign result.position = pos_reg;
    assign result.last     = is_last;

    // shared multiplier: x first, then y, then z
    always_comb
    begin
        if (ra_reg != '0)
            operand = x_reg;
        else if (rb_reg != '0)
            operand = y_reg;
        else
            operand = z_reg;
        prod     = 33'(acc_reg) * 33'(operand);
        prod_rnd = (34'(prod) + smb_pkg::Q15_ROUND) >>> 15;
    end

    // next element in basis order
    always_comb
    begin
        nd = deg_reg + 1'b1;
        na = '0;
        nb = '0;
        if (is_z_only)
        begin
            nd = deg_reg + 1'b1;
        end
        else if (is_xy)
        begin
            if (exp_a_reg < deg_reg)
            begin
                nd = deg_reg;
                na = exp_a_reg + 1'b1;
                nb = exp_b_reg - 1'b1;
            end
            else
            begin
                nb = deg_reg + 1'b1;
            end
        end
        else
        begin
            if (exp_b_reg < deg_reg - exp_a_reg)
            begin
                nd = deg_reg;
                na = exp_a_reg;
                nb = exp_b_reg + 1'b1;
            end
            else if (exp_a_reg < deg_reg)
            begin
                nd = deg_reg;
                na = exp_a_reg + 1'b1;
            end
        end
    end

    // element sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            x_reg     <= '0;
            y_reg     <= '0;
            z_reg     <= '0;
            deg_reg   <= '0;
            exp_a_reg <= '0;
            exp_b_reg <= '0;
            ra_reg    <= '0;
            rb_reg    <= '0;
            rc_reg    <= '0;
            acc_reg   <= '0;
            pos_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                B_IDLE:
                begin
                    if (!comp_empty)
                    begin
                        x_reg     <= comp.x;
                        y_reg     <= comp.y;
                        z_reg     <= comp.z;
                        deg_reg   <= '0;
                        exp_a_reg <= '0;
                        exp_b_reg <= '0;
                        ra_reg    <= '0;
                        rb_reg    <= '0;
                        rc_reg    <= '0;
                        acc_reg   <= smb_pkg::Q15_ONE;
                        pos_reg   <= '0;
                        state_reg <= B_CALC;
                    end
                end
                B_CALC:
                begin
                    if (mul_busy)
                    begin
                        acc_reg <= 17'(prod_rnd);
                        if (ra_reg != '0)
                            ra_reg <= ra_reg - 1'b1;
                        else if (rb_reg != '0)
                            rb_reg <= rb_reg - 1'b1;
                        else
                            rc_reg <= rc_reg - 1'b1;
                    end
                    else if (!res_full)
                    begin
                        if (is_last)
                        begin
                            state_reg <= B_IDLE;
                        end
                        else
                        begin
                            deg_reg   <= nd;
                            exp_a_reg <= na;
                            exp_b_reg <= nb;
                            ra_reg    <= na;
                            rb_reg    <= nb;
                            rc_reg    <= nd - na - nb;
                            acc_reg   <= smb_pkg::Q15_ONE;
                            pos_reg   <= pos_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/spherical_monomial_basis_unit.sv @@
// Channel   Ports                                   Transaction
// input     push, full, item                        push && !full
// result    empty, pop, result                      pop && !empty
// config    psel, penable, pwrite, paddr, pwdata,   psel && penable && pwrite
//           prdata, pready
//
// Front end: per sample, a bitwise square root, two multiplies and a CORDIC rotation,
// one step per cycle each.
// Back end: each element is formed on one shared Q1.15 multiplier.
// A two-entry queue parts front and back, a two-entry queue holds results.
// rst_n is asynchronous and clears all control state; no clearing pass.
// A stalled result side backs up the queues, then raises full.
`default_nettype none
module spherical_monomial_basis_unit #(
    parameter int MAX_DEGREE_LIMIT = 5,
    parameter int FRAC_BITS        = 15,
    parameter int CORDIC_STEPS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  smb_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output smb_pkg::out_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int CW = $bits(smb_pkg::comp_t);
    localparam int OW = $bits(smb_pkg::out_item_t);

    logic [2:0]         max_degree_reg;
    logic [1:0]         spatial_dim_reg;
    smb_pkg::cfg_t      cfg;
    smb_pkg::comp_t     comp_in;
    smb_pkg::comp_t     comp_out;
    logic               comp_push;
    logic               comp_full;
    logic               comp_pop;
    logic               comp_empty;
    smb_pkg::out_item_t res_in;
    logic               res_push;
    logic               res_full;
    logic               front_busy;

    assign pready          = 1'b1;
    assign full            = front_busy;
    assign cfg.max_degree  = max_degree_reg;
    assign cfg.spatial_dim = spatial_dim_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_degree_reg  <= smb_pkg::MAX_DEGREE_RESET;
            spatial_dim_reg <= smb_pkg::SPATIAL_DIM_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == smb_pkg::REG_MAX_DEGREE)
                max_degree_reg <= pwdata[2:0];
            else
                spatial_dim_reg <= pwdata[1:0];
        end
    end

    // register reads
    assign prdata = (paddr[2] == smb_pkg::REG_SPATIAL_DIM) ?
                    {30'b0, spatial_dim_reg} : {29'b0, max_degree_reg};

    smb_front #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .busy      (front_busy),
        .item      (item),
        .comp_push (comp_push),
        .comp_full (comp_full),
        .comp      (comp_in)
    );

    smb_fifo #(
        .WIDTH (CW),
        .DEPTH (2)
    ) u_comp_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (comp_push),
        .full  (comp_full),
        .wdata (comp_in),
        .pop   (comp_pop),
        .empty (comp_empty),
        .rdata (comp_out)
    );

    smb_back #(
        .MAX_DEGREE_LIMIT (MAX_DEGREE_LIMIT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .comp_empty (comp_empty),
        .comp_pop   (comp_pop),
        .comp       (comp_out),
        .res_push   (res_push),
        .res_full   (res_full),
        .result     (res_in)
    );

    smb_fifo #(
        .WIDTH (OW),
        .DEPTH (2)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .wdata (res_in),
        .pop   (pop),
        .empty (empty),
        .rdata (result)
    );
endmodule
`default_nettype wire

@@ design/smb_checker.sv @@
`default_nettype none
`include "spherical_monomial_basis_unit_assert.svh"
module smb_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               empty,
    input logic               pop,
    input smb_pkg::out_item_t result
);
    // position stays inside the largest basis
    `SMB_ASSERT_IMP(a_pos_range, !empty, result.position <= 6'd55, "position out of range")
    // the largest basis ends on its last element
    `SMB_ASSERT_IMP(a_last_at_end, !empty && result.position == 6'd55, result.last, "missing last")
    // an accepted sample keeps the front busy
    `SMB_ASSERT_NXT(a_busy_after_accept, push && !full, full, "front took a second sample")
    // a waiting result holds until taken
    `SMB_ASSERT_NXT(a_hold_stalled, !empty && !pop, !empty && $stable(result), "result changed")
endmodule

bind spherical_monomial_basis_unit smb_checker u_smb_checker (.*);
`default_nettype wire
